// ===== src/nklf_pkg.sv =====
package nklf_pkg;

    localparam int MAX_LOCI   = 16;
    localparam int MAX_WINDOW = 4;

    localparam int LI_W     = $clog2(MAX_LOCI);
    localparam int PAT_W    = MAX_WINDOW;
    localparam int ADDR_W   = LI_W + PAT_W;
    localparam int DEPTH    = MAX_LOCI * (1 << MAX_WINDOW);

    localparam int LOG_W    = 22;
    localparam int SUM_W    = LOG_W + LI_W;
    localparam int LOCI_W   = 5;
    localparam int KW_W     = 3;
    localparam int GENO_W   = 16;
    localparam int FIT_W    = 17;

    localparam int DIV_W    = 32;
    localparam int DIVS_W   = 5;
    localparam int X_W      = 22;
    localparam int Q_W      = X_W - 15;

    localparam logic [32:0]      EXP_ONE   = 33'h1_0000_0000;
    localparam logic [31:0]      HALF_Q32  = 32'h8000_0000;
    localparam logic [DIVS_W-1:0] EXP_TERMS = DIVS_W'(24);
    localparam logic [FIT_W-1:0] FIT_MAX   = FIT_W'(65536);

    localparam logic [1:0] CFG_LOCI   = 2'd0;
    localparam logic [1:0] CFG_WINDOW = 2'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quotient;
    } t_div_rsp;

endpackage

// ===== src/nklf_ram.sv =====
module nklf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/nklf_div.sv =====
module nklf_div
    import nklf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIVS_W-1:0]        r_rem;
    logic [DIV_W-1:0]         r_quo;
    logic [DIVS_W-1:0]        r_d;
    logic [$clog2(DIV_W)-1:0] r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [DIVS_W:0]          w_rem2;
    logic                     w_ge;

    // one quotient bit a cycle, restoring
    assign w_rem2 = {r_rem, r_quo[DIV_W-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_d    <= i_req.divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= DIVS_W'(w_rem2 - {1'b0, r_d});
                end else begin
                    r_rem <= w_rem2[DIVS_W-1:0];
                end
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== src/nk_landscape_fitness.sv =====
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser command, tdata locus..genotype
// m_axis    out  m_axis_tvalid/tready      tdata fitness, genotype_echo
// cfg       in   i_cfg_valid/o_cfg_ready   index, data (always ready)
//
// a write word only writes the table; an evaluate word walks the table once per locus,
// runs the mean division, then one series term per pass for each of two exp runs through
// the shared serial divider, and one power step per half-unit of the mean magnitude (up to 64)
// reset is synchronous active low; the table is not cleared
// input is not ready from an evaluate word until its result word is taken
module nk_landscape_fitness
    import nklf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // locus[3:0] pattern[7:4] entry_log[29:8] genotype[45:30]
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // fitness[16:0] genotype_echo[32:17]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SUM_RD, S_SUM_ACC, S_MEAN, S_MEAN_WAIT, S_EXP_INIT, S_EXP_MUL,
        S_EXP_DIV, S_EXP_WAIT, S_EXP_END, S_POW, S_POW_MUL, S_POW_ACC, S_ROUND, S_OUT
    } t_state;

    t_state              r_state;
    logic [LOCI_W-1:0]   r_loci;
    logic [KW_W-1:0]     r_wbits;

    logic [GENO_W-1:0]   r_geno;
    logic [LOCI_W-1:0]   r_nl;
    logic [PAT_W-1:0]    r_mask;
    logic [PAT_W-1:0]    r_win;
    logic [LI_W-1:0]     r_i;
    logic [LI_W-1:0]     r_pos;
    logic signed [SUM_W-1:0] r_sum;
    logic [Q_W-1:0]      r_q;
    logic [14:0]         r_r;
    logic [31:0]         r_v;
    logic [31:0]         r_t;
    logic [32:0]         r_s;
    logic [DIVS_W-1:0]   r_n;
    logic                r_phase;
    logic [31:0]         r_h;
    logic [32:0]         r_p;
    logic [63:0]         r_prod;
    logic [FIT_W-1:0]    r_fit;

    logic [LOG_W-1:0]    w_entry;
    logic [LOCI_W-1:0]   w_nl;
    logic [KW_W-1:0]     w_kw;
    logic [PAT_W-1:0]    w_seed;
    logic [PAT_W-1:0]    w_mask;
    logic [31:0]         w_ma;
    logic [31:0]         w_mb;
    logic [63:0]         w_mul;
    logic [LOG_W-1:0]    w_rdata;
    logic                w_we;
    logic [SUM_W:0]      w_abs;
    logic [64:0]         w_pround;
    logic [33:0]         w_fround;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    assign w_entry = s_axis_tdata[29:8];

    // clamp n to 1..MAX_LOCI and k to MAX_WINDOW then to n
    always_comb begin
        logic [KW_W-1:0] kw_sat;
        if (r_loci == '0) begin
            w_nl = LOCI_W'(1);
        end else if (r_loci > LOCI_W'(MAX_LOCI)) begin
            w_nl = LOCI_W'(MAX_LOCI);
        end else begin
            w_nl = r_loci;
        end
        kw_sat = (r_wbits > KW_W'(MAX_WINDOW)) ? KW_W'(MAX_WINDOW) : r_wbits;
        w_kw = ({2'b0, kw_sat} > w_nl) ? KW_W'(w_nl) : kw_sat;
    end

    // genotype bit 0 lands in the top bit of the window
    always_comb begin
        w_seed = '0;
        for (int b = 0; b < MAX_WINDOW; b++) begin
            if (b < int'(w_kw)) begin
                w_seed[b] = s_axis_tdata[30 + int'(w_kw) - 1 - b];
            end
        end
        w_mask = PAT_W'((1 << w_kw) - 1);
    end

    assign w_ma     = (r_state == S_POW_MUL) ? r_p[31:0] : r_t;
    assign w_mb     = (r_state == S_POW_MUL) ? r_h : r_v;
    assign w_mul    = w_ma * w_mb;
    assign w_abs    = (SUM_W + 1)'(-r_sum) + (SUM_W + 1)'(r_nl >> 1);
    assign w_pround = {1'b0, r_prod} + 65'(HALF_Q32);
    assign w_fround = {1'b0, r_p} + 34'(16'h8000);

    assign w_we = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE);

    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_prod[63:32];
        w_div_req.divisor  = r_n;
        if (r_state == S_MEAN) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = DIV_W'(w_abs);
            w_div_req.divisor  = r_nl;
        end else if (r_state == S_EXP_DIV) begin
            w_div_req.start    = 1'b1;
        end
    end

    nklf_ram #(
        .WIDTH (LOG_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({s_axis_tdata[LI_W-1:0], s_axis_tdata[4 +: PAT_W]}),
        .i_wdata (w_entry),
        .i_raddr ({r_i, r_win}),
        .o_rdata (w_rdata)
    );

    nklf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_loci  <= LOCI_W'(16);
            r_wbits <= KW_W'(2);
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LOCI:   r_loci  <= i_cfg_data;
                    CFG_WINDOW: r_wbits <= i_cfg_data[KW_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tuser == CMD_EVAL) begin
                        r_geno  <= s_axis_tdata[45:30];
                        r_nl    <= w_nl;
                        r_mask  <= w_mask;
                        r_win   <= w_seed;
                        r_i     <= '0;
                        r_pos   <= ({2'b0, w_kw} == w_nl) ? '0 : LI_W'(w_kw);
                        r_sum   <= '0;
                        r_state <= S_SUM_RD;
                    end
                end
                S_SUM_RD: begin
                    r_win   <= {r_win[PAT_W-2:0], r_geno[r_pos]} & r_mask;
                    r_pos   <= ({1'b0, r_pos} == r_nl - 1'b1) ? '0 : r_pos + 1'b1;
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    r_sum <= r_sum + SUM_W'(signed'(w_rdata));
                    r_i   <= r_i + 1'b1;
                    if ({1'b0, r_i} == r_nl - 1'b1) begin
                        r_state <= S_MEAN;
                        if (r_sum + SUM_W'(signed'(w_rdata)) >= 0) begin
                            r_fit   <= FIT_MAX;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_SUM_RD;
                    end
                end
                S_MEAN: r_state <= S_MEAN_WAIT;
                S_MEAN_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_q     <= w_div_rsp.quotient[X_W-1:15];
                        r_r     <= w_div_rsp.quotient[14:0];
                        r_v     <= HALF_Q32;
                        r_phase <= 1'b0;
                        r_state <= S_EXP_INIT;
                    end
                end
                S_EXP_INIT: begin
                    r_t <= r_v;
                    r_n <= DIVS_W'(2);
                    if (r_v == '0) begin
                        r_s     <= EXP_ONE;
                        r_state <= S_EXP_END;
                    end else begin
                        r_s     <= EXP_ONE - 33'(r_v);
                        r_state <= S_EXP_MUL;
                    end
                end
                S_EXP_MUL: begin
                    r_prod  <= w_mul;
                    r_state <= S_EXP_DIV;
                end
                S_EXP_DIV: r_state <= S_EXP_WAIT;
                S_EXP_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_t <= w_div_rsp.quotient;
                        if (w_div_rsp.quotient == '0) begin
                            r_state <= S_EXP_END;
                        end else begin
                            // odd terms subtract, even terms add
                            if (r_n[0]) begin
                                r_s <= r_s - 33'(w_div_rsp.quotient);
                            end else begin
                                r_s <= r_s + 33'(w_div_rsp.quotient);
                            end
                            if (r_n == EXP_TERMS) begin
                                r_state <= S_EXP_END;
                            end else begin
                                r_n     <= r_n + 1'b1;
                                r_state <= S_EXP_MUL;
                            end
                        end
                    end
                end
                S_EXP_END: begin
                    if (!r_phase) begin
                        r_h     <= r_s[31:0];
                        r_v     <= {1'b0, r_r, 16'b0};
                        r_phase <= 1'b1;
                        r_state <= S_EXP_INIT;
                    end else begin
                        r_p     <= r_s;
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    if (r_q == '0) begin
                        r_state <= S_ROUND;
                    end else if (r_p[32]) begin
                        // exactly one times h is h
                        r_p <= {1'b0, r_h};
                        r_q <= r_q - 1'b1;
                    end else begin
                        r_state <= S_POW_MUL;
                    end
                end
                S_POW_MUL: begin
                    r_prod  <= w_mul;
                    r_state <= S_POW_ACC;
                end
                S_POW_ACC: begin
                    r_p     <= w_pround[64:32];
                    r_q     <= r_q - 1'b1;
                    r_state <= S_POW;
                end
                S_ROUND: begin
                    if (w_fround[33:16] > 18'(FIT_MAX)) begin
                        r_fit <= FIT_MAX;
                    end else begin
                        r_fit <= w_fround[32:16];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {7'b0, r_geno, r_fit};
    assign o_cfg_ready   = 1'b1;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result word waits");

    a_fit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= FIT_MAX))
        else $error("fitness above one");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_MEAN_WAIT || r_state == S_EXP_WAIT))
        else $error("divider finished outside a wait state");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider restarted while busy");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import nklf_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd20_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;

    typedef struct {
        logic [FIT_W-1:0]  fitness;
        logic [GENO_W-1:0] genotype;
    } t_fitness_word;

    // predictor state
    logic signed [LOG_W-1:0] log_table [DEPTH];
    logic [LOCI_W-1:0]       loci_reg;
    logic [KW_W-1:0]         window_reg;

    t_fitness_word fitness_q[$];
    int            errors;
    int            writes_sent;
    int            evals_sent;
    int            words_checked;
    longint        cycles = 0;
    int            burst_left;
    int            stall_left = 0;

    nk_landscape_fitness dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", fitness_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls of random length, with long ready stretches between
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 15) == 0)
                stall_left <= $urandom_range(1, 24);
        end
    end

    always @(posedge i_clk) begin
        t_fitness_word exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (fitness_q.size() == 0) begin
                $error("result word with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                exp_w = fitness_q.pop_front();
                words_checked++;
                if (m_axis_tdata[16:0] !== exp_w.fitness) begin
                    $error("fitness expected %0d got %0d", exp_w.fitness, m_axis_tdata[16:0]);
                    errors++;
                end
                if (m_axis_tdata[32:17] !== exp_w.genotype) begin
                    $error("genotype_echo expected %h got %h", exp_w.genotype,
                           m_axis_tdata[32:17]);
                    errors++;
                end
            end
        end
    end

    // exp(-v) for v in Q32, truncated alternating series
    function automatic logic [63:0] exp_neg(input logic [63:0] v);
        logic [63:0] s;
        logic [63:0] t;
        s = 64'h1_0000_0000;
        t = 64'h1_0000_0000;
        for (int n = 1; n <= 24; n++) begin
            t = ((t * v) >> 32) / n;
            if (t == 0)
                break;
            if (n % 2 == 1)
                s = s - t;
            else
                s = s + t;
        end
        return s;
    endfunction

    function automatic logic [FIT_W-1:0] geo_mean(input longint sum, input int nl);
        logic [63:0] mag;
        logic [63:0] x;
        logic [63:0] p;
        logic [63:0] h;
        logic [63:0] q;
        if (sum >= 0)
            return FIT_MAX;
        mag = -sum;
        x   = (mag + nl / 2) / nl;
        q   = x >> 15;
        h   = exp_neg(64'h8000_0000);
        p   = exp_neg((x & 64'h7FFF) << 16);
        for (longint i = 0; i < q; i++)
            p = (p * h + 64'h8000_0000) >> 32;
        p = (p + 64'h8000) >> 16;
        if (p > 65536)
            p = 65536;
        return p[FIT_W-1:0];
    endfunction

    function automatic logic [FIT_W-1:0] eval_fitness(input logic [GENO_W-1:0] geno);
        int     nl;
        int     kw;
        int     win;
        int     mask;
        int     pos;
        longint sum;
        nl = loci_reg;
        if (nl == 0)
            nl = 1;
        if (nl > MAX_LOCI)
            nl = MAX_LOCI;
        kw = window_reg;
        if (kw > MAX_WINDOW)
            kw = MAX_WINDOW;
        if (kw > nl)
            kw = nl;
        mask = (1 << kw) - 1;
        win  = 0;
        sum  = 0;
        // seed reversed: genotype bit 0 lands in the top of the window
        for (int j = 0; j < kw; j++)
            win = (win << 1) | geno[j];
        for (int i = 0; i < nl; i++) begin
            pos = (i + kw) % nl;
            sum += log_table[i * 16 + (win & 15)];
            win = ((win << 1) | geno[pos]) & mask;
        end
        return geo_mean(sum, nl);
    endfunction

    task automatic send_word(input logic cmd, input logic [3:0] locus, input logic [3:0] pat,
                             input logic signed [LOG_W-1:0] entry,
                             input logic [GENO_W-1:0] geno);
        t_fitness_word w;
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, geno, entry, pat, locus};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        if (cmd == CMD_WRITE) begin
            log_table[locus * 16 + pat] = entry;
            writes_sent++;
        end else begin
            w.fitness  = eval_fitness(geno);
            w.genotype = geno;
            fitness_q  = {fitness_q, w};
            evals_sent++;
        end
    endtask

    task automatic write_entry(input int locus, input int pat, input int entry);
        send_word(CMD_WRITE, locus[3:0], pat[3:0], entry[LOG_W-1:0], '0);
    endtask

    task automatic evaluate(input logic [GENO_W-1:0] geno);
        send_word(CMD_EVAL, '0, '0, '0, geno);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (fitness_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LOCI)
            loci_reg = value;
        else if (idx == CFG_WINDOW)
            window_reg = value[KW_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_shape(input int nl, input int kw);
        drain();
        write_reg(CFG_LOCI, nl[4:0]);
        write_reg(CFG_WINDOW, kw[4:0]);
    endtask

    function automatic int rand_entry();
        case ($urandom_range(0, 3))
            0: return -$urandom_range(0, 2000);
            1: return -$urandom_range(0, 200000);
            default: return -$urandom_range(0, 2097152);
        endcase
    endfunction

    task automatic test_table_load();
        for (int a = 0; a < DEPTH; a++)
            write_entry(a / 16, a % 16, rand_entry());
    endtask

    task automatic test_directed();
        set_shape(1, 0);
        write_entry(0, 0, -2097152);   // deepest mean magnitude
        evaluate(16'h0000);
        write_entry(0, 0, 0);          // mean of zero gives exactly one
        evaluate(16'hFFFF);
        write_entry(0, 0, 5);          // positive log saturates
        evaluate(16'h1234);
        write_entry(0, 0, -1);
        evaluate(16'h0001);
        write_entry(15, 15, -1048576);
        set_shape(16, 4);
        evaluate(16'h0000);
        evaluate(16'hFFFF);
        evaluate(16'hAAAA);
        evaluate(16'h5555);
        set_shape(16, 7);              // window wider than the maximum
        evaluate(16'h8001);
        set_shape(2, 4);               // window wider than the loci in use
        evaluate(16'h0002);
        set_shape(0, 1);               // zero loci acts as one
        evaluate(16'h0001);
        set_shape(31, 3);              // above the maximum acts as sixteen
        evaluate(16'hC3A5);
        set_shape(3, 3);
        evaluate(16'h0005);
    endtask

    task automatic test_random(input int words);
        int done;
        int loc;
        done = 0;
        while (done < words) begin
            set_shape($urandom_range(0, 31), $urandom_range(0, 7));
            repeat ($urandom_range(40, 160)) begin
                loc = $urandom_range(0, 15);
                if ($urandom_range(0, 2) == 0)
                    evaluate(16'($urandom_range(0, 65535)));
                else
                    write_entry(loc, $urandom_range(0, 15), rand_entry());
                done++;
            end
        end
        set_shape(16, 2);
        repeat (40) evaluate(16'($urandom_range(0, 65535)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        loci_reg      = 5'd16;
        window_reg    = 3'd2;
        errors        = 0;
        writes_sent   = 0;
        evals_sent    = 0;
        words_checked = 0;
        burst_left    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_directed();
        test_random(1000);
        drain();

        $display("table writes %0d, evaluations %0d, results checked %0d",
                 writes_sent, evals_sent, words_checked);
        $display("covered loci 0..31 and windows 0..7 incl. clamped and saturated cases");
        if (errors == 0 && fitness_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/nklf_pkg.sv
src/nklf_ram.sv
src/nklf_div.sv
src/nk_landscape_fitness.sv
sim/testbench.sv
